FILE: rtl/mbrx_pkg.sv
// shared constants and types for the modbus rtu frame receiver
package mbrx_pkg;

  localparam int unsigned BufferDepth = 32;
  localparam int unsigned PosW        = $clog2(BufferDepth);
  localparam int unsigned PosNxW      = PosW + 1;
  localparam int unsigned LenW        = 9;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [7:0] FuncReadHolding   = 8'h03;
  localparam logic [7:0] FuncWriteSingle   = 8'h06;
  localparam logic [7:0] FuncWriteMultiple = 8'h10;

  localparam logic [LenW-1:0] LenShort = LenW'(8);
  localparam logic [LenW-1:0] LenLong  = LenW'(9);
  localparam logic [LenW-1:0] DepthLen = LenW'(BufferDepth);

  localparam logic [PosW-1:0] PosAddr     = PosW'(0);
  localparam logic [PosW-1:0] PosFunc     = PosW'(1);
  localparam logic [PosW-1:0] PosPayload  = PosW'(2);
  localparam logic [PosW-1:0] PosByteCnt  = PosW'(6);

  typedef struct packed {
    logic       frame_dropped;
    logic       frame_ok;
  } mbrx_flags_t;

endpackage

FILE: rtl/mbrx_crc_step.sv
// crc-16 update over one byte, reflected polynomial, bitwise unrolled
module mbrx_crc_step (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import mbrx_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

FILE: rtl/modbus_rtu_frame_receiver_top.sv
// modbus rtu request frame receiver with crc-16 check, top level
//
// bytes from the uart enter on the slave stream, one byte per transfer.
// each byte leaves on the master stream with its frame buffer position,
// so a downstream buffer can write it; tuser flags the byte that
// completes a frame with a good crc (frame_ok) or the byte that aborts
// the hunt on a bad function code, crc mismatch or overlong frame
// (frame_dropped).
// each accepted byte is registered and shown on the master stream in
// the cycle after its transfer. throughput is one byte per cycle while
// the master stream does not stall; the frame state and the eight crc
// bit steps settle combinationally between input and output register.
// the output register is refilled in the same cycle it is taken, so
// s_axis_tready_o is low only while a result waits and m_axis_tready_i
// is low.
// reset clears the output valid, puts the receiver back to hunting for
// the address byte and sets the station address to 1. cfg_we_i writes
// the station address; it is to be written only while the stream is idle, which the block itself does not enforce.
module modbus_rtu_frame_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // store_index[4:0], store_byte[12:5], zero fill
  output mbrx_pkg::mbrx_flags_t m_axis_tuser_o  // frame_ok[0], frame_dropped[1]
);
  import mbrx_pkg::*;

  logic [7:0]      station_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [LenW-1:0] len_q, len_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     crc_in, crc_next;

  logic            out_valid_q;
  logic [4:0]      idx_q;
  logic [7:0]      byte_q;
  mbrx_flags_t     flags_q, flags_d;

  logic            accept;
  logic [7:0]      b;
  logic [LenW-1:0] pos_ext;
  logic [LenW-1:0] len_v;
  logic [PosNxW-1:0] pos_nx;
  logic            overlong;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i;
  assign pos_ext         = LenW'(pos_q);
  assign pos_nx          = PosNxW'(pos_q) + PosNxW'(1);
  assign crc_in          = (pos_q == PosAddr) ? CrcInit : crc_q;

  mbrx_crc_step u_crc (
    .crc_i  (crc_in),
    .byte_i (b),
    .crc_o  (crc_next)
  );

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    crc_d    = crc_q;
    flags_d  = '0;
    len_v    = len_q;
    overlong = 1'b0;
    if (accept) begin
      if (pos_q == PosAddr) begin
        crc_d = crc_next;
        if (b == station_q) begin
          pos_d = PosFunc;
        end
      end else if (pos_q == PosFunc) begin
        crc_d = crc_next;
        if (b inside {FuncReadHolding, FuncWriteSingle}) begin
          len_d = LenShort;
          pos_d = PosPayload;
        end else if (b == FuncWriteMultiple) begin
          len_d = LenLong;
          pos_d = PosPayload;
        end else begin
          flags_d.frame_dropped = 1'b1;
          pos_d = PosAddr;
          len_d = '0;
        end
      end else begin
        if (len_q > LenShort && pos_q == PosByteCnt) begin
          len_v    = len_q + LenW'(b);
          len_d    = len_v;
          overlong = len_v > DepthLen;
        end
        if (overlong) begin
          flags_d.frame_dropped = 1'b1;
          pos_d = PosAddr;
          len_d = '0;
        end else if (pos_ext + LenW'(2) == len_v) begin
          if (crc_q[7:0] == b) begin
            pos_d = pos_nx[PosW-1:0];
          end else begin
            flags_d.frame_dropped = 1'b1;
            pos_d = PosAddr;
            len_d = '0;
          end
        end else if (pos_ext + LenW'(1) == len_v) begin
          flags_d.frame_ok      = (crc_q[15:8] == b);
          flags_d.frame_dropped = (crc_q[15:8] != b);
          pos_d = PosAddr;
          len_d = '0;
        end else begin
          crc_d = crc_next;
          if (pos_nx >= PosNxW'(BufferDepth)) begin
            pos_d = PosAddr;
            len_d = '0;
          end else begin
            pos_d = pos_nx[PosW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q   <= 8'd1;
      pos_q       <= PosAddr;
      len_q       <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        station_q <= cfg_wdata_i;
      end
      pos_q <= pos_d;
      len_q <= len_d;
      crc_q <= crc_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= pos_ext[4:0];
      byte_q  <= b;
      flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, byte_q, idx_q};
  assign m_axis_tuser_o  = flags_q;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(flags_q.frame_ok && flags_q.frame_dropped))
    else $error("frame_ok and frame_dropped both set");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted byte not presented");

  a_len_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != PosAddr && pos_q != PosFunc) |-> (len_q >= LenShort))
    else $error("payload position without frame length");

  a_ok_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && flags_q.frame_ok) |-> (idx_q >= 5'd7))
    else $error("frame completed too early");

  a_restart_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (flags_d.frame_ok || flags_d.frame_dropped)) |=>
      (pos_q == PosAddr && len_q == '0))
    else $error("hunt not restarted after frame end");

endmodule
